/* src/etf_pkg.sv */
`timescale 1ns / 1ps
package etf_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int VAL_W      = 32;
  localparam int MAX_ITER   = 4096;
  localparam int MAX_DIM    = 4096;
  localparam int PAL_DEPTH  = 257;
  localparam int PAL_AW     = 9;
  localparam int STEP_W     = 13;
  localparam int PIX_W      = 12;
  localparam int SPAN_W     = 31;
  localparam int QUO_W      = SPAN_W + PIX_W;

  localparam logic [PAL_AW-1:0] INSIDE_IDX = PAL_AW'(PAL_DEPTH - 1);
  localparam logic [31:0] INV_ASPECT = 32'd2415920161;
  localparam logic signed [VAL_W:0] ESCAPE_R2 = (VAL_W+1)'(64'sd4 <<< FRAC_BITS);
  localparam logic signed [VAL_W-1:0] JULIA_RE =
    -VAL_W'(((64'd7 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [VAL_W-1:0] JULIA_IM =
    VAL_W'(((64'd27 << FRAC_BITS) + 64'd50) / 64'd100);

  typedef enum logic {
    OP_RENDER = 1'b0,
    OP_PAL_WR = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CFG_KIND   = 3'd0,
    CFG_LIMIT  = 3'd1,
    CFG_XMIN   = 3'd2,
    CFG_XSPAN  = 3'd3,
    CFG_YMIN   = 3'd4,
    CFG_YSPAN  = 3'd5,
    CFG_WIDTH  = 3'd6,
    CFG_HEIGHT = 3'd7
  } cfg_idx_e;

  localparam logic [1:0] KIND_JULIA = 2'd1;
  localparam logic [1:0] KIND_SHIP  = 2'd2;

  typedef struct packed {
    op_e                op;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [PAL_AW-1:0]  palette_index;
    logic [31:0]        palette_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        pixel_color;
    logic [STEP_W-1:0]  escape_step;
    logic               inside_set;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                fractal_kind;
    logic [STEP_W-1:0]         iteration_limit;
    logic signed [VAL_W-1:0]   view_x_min;
    logic [SPAN_W-1:0]         view_x_span;
    logic signed [VAL_W-1:0]   view_y_min;
    logic [SPAN_W-1:0]         view_y_span;
    logic [STEP_W-1:0]         frame_width;
    logic [STEP_W-1:0]         frame_height;
  } cfg_t;

  // one request between front and back
  typedef struct packed {
    logic                      is_write;
    logic [PAL_AW-1:0]         pal_idx;
    logic [31:0]               pal_color;
    logic                      ship;
    logic [STEP_W-1:0]         limit;
    logic signed [VAL_W-1:0]   zx;
    logic signed [VAL_W-1:0]   zy;
    logic signed [VAL_W-1:0]   cx;
    logic signed [VAL_W-1:0]   cy;
  } req_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [67:0] v);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = (68'sd1 <<< (VAL_W - 1)) - 68'sd1;
    lo = -(68'sd1 <<< (VAL_W - 1));
    if (v > hi) return VAL_W'(hi);
    if (v < lo) return VAL_W'(lo);
    return VAL_W'(v);
  endfunction

endpackage

/* src/etf_ram.sv */
`timescale 1ns / 1ps
module etf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/etf_front.sv */
`timescale 1ns / 1ps
module etf_front
  import etf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     push_o,
  output req_t     push_data_o,
  input  logic     full_i
);

  typedef enum logic [2:0] {
    F_IDLE, F_DIV, F_ADD, F_SCALE, F_PUSH
  } fstate_e;

  fstate_e state_q;
  logic [5:0] cnt_q;
  logic [QUO_W-1:0] num_x_q, num_y_q;
  logic [STEP_W:0] rem_x_q, rem_y_q;
  logic [STEP_W-1:0] div_x_q, div_y_q;
  logic signed [VAL_W-1:0] py_q;
  logic julia_q;
  req_t req_q;

  logic [STEP_W-1:0] div_x, div_y;
  logic [STEP_W:0] trial_x, trial_y;
  logic bit_x, bit_y;
  logic signed [VAL_W-1:0] px_sum, py_sum;
  logic signed [65:0] scale_prod;

  function automatic logic [STEP_W-1:0] clamp_dim(input logic [STEP_W-1:0] f);
    if (f == '0) return STEP_W'(1);
    if (f > STEP_W'(MAX_DIM)) return STEP_W'(MAX_DIM);
    return f;
  endfunction

  always_comb begin
    div_x = clamp_dim(cfg_i.frame_width);
    div_y = clamp_dim(cfg_i.frame_height);
    trial_x = {rem_x_q[STEP_W-1:0], num_x_q[QUO_W-1]};
    trial_y = {rem_y_q[STEP_W-1:0], num_y_q[QUO_W-1]};
    bit_x = trial_x >= {1'b0, div_x_q};
    bit_y = trial_y >= {1'b0, div_y_q};
    px_sum = sat_val(68'(cfg_i.view_x_min) + $signed({25'd0, num_x_q}));
    py_sum = sat_val(68'(cfg_i.view_y_min) + $signed({25'd0, num_y_q}));
    scale_prod = 66'(py_q) * $signed({34'd0, INV_ASPECT});
  end

  assign in_stall_o  = state_q != F_IDLE;
  assign push_o      = state_q == F_PUSH && !full_i;
  assign push_data_o = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            req_q.is_write  <= in_data_i.op == OP_PAL_WR;
            req_q.pal_idx   <= in_data_i.palette_index;
            req_q.pal_color <= in_data_i.palette_color;
            req_q.ship      <= cfg_i.fractal_kind == KIND_SHIP;
            req_q.limit     <= cfg_i.iteration_limit > STEP_W'(MAX_ITER) ?
                               STEP_W'(MAX_ITER) : cfg_i.iteration_limit;
            julia_q   <= cfg_i.fractal_kind == KIND_JULIA;
            num_x_q   <= QUO_W'(cfg_i.view_x_span * in_data_i.pixel_x);
            num_y_q   <= QUO_W'(cfg_i.view_y_span * in_data_i.pixel_y);
            rem_x_q   <= '0;
            rem_y_q   <= '0;
            div_x_q   <= div_x;
            div_y_q   <= div_y;
            cnt_q     <= '0;
            state_q   <= in_data_i.op == OP_PAL_WR ? F_PUSH : F_DIV;
          end
        end
        F_DIV: begin
          // restoring division, one quotient bit a cycle for x and y
          rem_x_q <= bit_x ? trial_x - {1'b0, div_x_q} : trial_x;
          rem_y_q <= bit_y ? trial_y - {1'b0, div_y_q} : trial_y;
          num_x_q <= {num_x_q[QUO_W-2:0], bit_x};
          num_y_q <= {num_y_q[QUO_W-2:0], bit_y};
          cnt_q   <= cnt_q + 6'd1;
          if (cnt_q == 6'(QUO_W - 1)) begin
            state_q <= F_ADD;
          end
        end
        F_ADD: begin
          py_q <= py_sum;
          if (julia_q) begin
            req_q.zx <= px_sum;
            req_q.zy <= py_sum;
            req_q.cx <= JULIA_RE;
            req_q.cy <= JULIA_IM;
            state_q  <= F_PUSH;
          end else begin
            req_q.zx <= '0;
            req_q.zy <= '0;
            req_q.cx <= px_sum;
            state_q  <= F_SCALE;
          end
        end
        F_SCALE: begin
          // aspect correction, floor of the product over 2^32
          req_q.cy <= scale_prod[63:32];
          state_q  <= F_PUSH;
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

/* src/etf_fifo.sv */
`timescale 1ns / 1ps
module etf_fifo
  import etf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output req_t pop_data_o,
  output logic empty_o
);

  req_t slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

/* src/etf_back.sv */
`timescale 1ns / 1ps
module etf_back
  import etf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  req_t      req_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_EVAL, B_DIV, B_READ, B_WAIT
  } bstate_e;

  localparam int NUM_W = 20;

  bstate_e state_q;
  logic ship_q, inside_q;
  logic [STEP_W-1:0] limit_q, it_q, esc_q;
  logic signed [VAL_W-1:0] zx_q, zy_q, cx_q, cy_q;
  logic signed [65:0] p_xx_q, p_yy_q, p_xy_q;
  logic [NUM_W-1:0] num_q;
  logic [STEP_W:0] rem_q;
  logic [4:0] cnt_q;
  logic out_valid_q;
  out_item_t out_q;

  logic signed [VAL_W:0] tx, ty;
  logic signed [VAL_W-1:0] x2, y2, xy, zx_next, zy_next;
  logic escaped;
  logic [STEP_W:0] trial;
  logic qbit;
  logic ram_we, ram_re;
  logic [PAL_AW-1:0] ram_raddr;
  logic [31:0] ram_rdata;

  always_comb begin
    tx = 33'(zx_q);
    ty = 33'(zy_q);
    if (ship_q) begin
      if (tx < 0) tx = -tx;
      if (ty < 0) ty = -ty;
    end
    x2 = sat_val(68'(p_xx_q >>> FRAC_BITS));
    y2 = sat_val(68'(p_yy_q >>> FRAC_BITS));
    xy = sat_val(68'(p_xy_q >>> (FRAC_BITS - 1)));
    escaped = (33'(x2) + 33'(y2)) > ESCAPE_R2;
    zx_next = sat_val(68'(x2) - 68'(y2) + 68'(cx_q));
    zy_next = sat_val(68'(xy) + 68'(cy_q));
    trial = {rem_q[STEP_W-1:0], num_q[NUM_W-1]};
    qbit = trial >= {1'b0, limit_q};
  end

  assign pop_o     = state_q == B_IDLE && !empty_i;
  assign ram_we    = pop_o && req_i.is_write && req_i.pal_idx <= INSIDE_IDX;
  assign ram_re    = state_q == B_READ;
  assign ram_raddr = inside_q ? INSIDE_IDX : {1'b0, num_q[7:0]};

  etf_ram #(.WIDTH(32), .DEPTH(PAL_DEPTH)) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_i.pal_idx),
    .wdata_i (req_i.pal_color),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      // the wait state decides the output valid itself
      if (out_valid_q && !out_stall_i && state_q != B_WAIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!empty_i && !req_i.is_write) begin
            ship_q  <= req_i.ship;
            limit_q <= req_i.limit;
            zx_q    <= req_i.zx;
            zy_q    <= req_i.zy;
            cx_q    <= req_i.cx;
            cy_q    <= req_i.cy;
            it_q    <= '0;
            if (req_i.limit == '0) begin
              inside_q <= 1'b1;
              esc_q    <= '0;
              state_q  <= B_READ;
            end else begin
              inside_q <= 1'b0;
              state_q  <= B_MUL;
            end
          end
        end
        B_MUL: begin
          p_xx_q  <= 66'(zx_q) * 66'(zx_q);
          p_yy_q  <= 66'(zy_q) * 66'(zy_q);
          p_xy_q  <= 66'(tx) * 66'(ty);
          state_q <= B_EVAL;
        end
        B_EVAL: begin
          if (escaped) begin
            // palette entry is step * 256 / limit
            esc_q   <= it_q;
            num_q   <= {it_q[11:0], 8'd0};
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= B_DIV;
          end else begin
            zx_q <= zx_next;
            zy_q <= zy_next;
            it_q <= it_q + STEP_W'(1);
            if (it_q + STEP_W'(1) == limit_q) begin
              inside_q <= 1'b1;
              esc_q    <= limit_q;
              state_q  <= B_READ;
            end else begin
              state_q <= B_MUL;
            end
          end
        end
        B_DIV: begin
          rem_q <= qbit ? trial - {1'b0, limit_q} : trial;
          num_q <= {num_q[NUM_W-2:0], qbit};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(NUM_W - 1)) begin
            state_q <= B_READ;
          end
        end
        B_READ: state_q <= B_WAIT;
        B_WAIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q       <= 1'b1;
            out_q.pixel_color <= ram_rdata;
            out_q.escape_step <= esc_q;
            out_q.inside_set  <= inside_q;
            state_q           <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  a_step_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_EVAL |-> it_q < limit_q) else $error("iteration past limit");
  a_entry_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_READ && !inside_q) |-> num_q[NUM_W-1:8] == '0)
    else $error("palette entry out of range");
  a_inside_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_WAIT && inside_q) |-> esc_q == limit_q)
    else $error("inside point with wrong step");
  a_escape_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_WAIT && !inside_q) |-> esc_q < limit_q)
    else $error("escape step not below limit");

endmodule

/* src/escape_time_fractal_pixel_top.sv */
// render request: the front runs a 43-step coordinate divider, the sum and, except in Julia mode, the aspect multiply,
// then the back repeats per iteration square products, then update and escape test,
// runs the palette-index divider on escape, and ends with the palette lookup and output
// palette write request: no division or iteration; front and back overlap through a 2-deep queue
// reset restores the configuration defaults and empties queue and output register
// palette memory is undefined after reset until written, no clearing pass
`timescale 1ns / 1ps
module escape_time_fractal_pixel_top
  import etf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t cfg_q;
  logic push, full, pop, empty;
  req_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fractal_kind    <= '0;
      cfg_q.iteration_limit <= STEP_W'(100);
      cfg_q.view_x_min      <= -32'sd536870912;
      cfg_q.view_x_span     <= SPAN_W'(1073741824);
      cfg_q.view_y_min      <= -32'sd536870912;
      cfg_q.view_y_span     <= SPAN_W'(1073741824);
      cfg_q.frame_width     <= STEP_W'(640);
      cfg_q.frame_height    <= STEP_W'(480);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_KIND:   cfg_q.fractal_kind    <= cfg_data_i[1:0];
        CFG_LIMIT:  cfg_q.iteration_limit <= cfg_data_i[STEP_W-1:0];
        CFG_XMIN:   cfg_q.view_x_min      <= cfg_data_i;
        CFG_XSPAN:  cfg_q.view_x_span     <= cfg_data_i[SPAN_W-1:0];
        CFG_YMIN:   cfg_q.view_y_min      <= cfg_data_i;
        CFG_YSPAN:  cfg_q.view_y_span     <= cfg_data_i[SPAN_W-1:0];
        CFG_WIDTH:  cfg_q.frame_width     <= cfg_data_i[STEP_W-1:0];
        CFG_HEIGHT: cfg_q.frame_height    <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  etf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  etf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  etf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .req_i       (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* bench/escape_time_fractal_pixel_checker.sv */
`timescale 1ns / 1ps
module escape_time_fractal_pixel_checker
  import etf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam longint R2_LIMIT = 64'sd4 <<< 28;
  localparam longint SEED_RE = -(((64'sd7 <<< 28) + 64'sd5) / 64'sd10);
  localparam longint SEED_IM = ((64'sd27 <<< 28) + 64'sd50) / 64'sd100;
  localparam longint ASPECT_Q32 = 64'sd2415920161;

  logic [1:0]  kind_q;
  logic [12:0] limit_q;
  longint      xmin_q, ymin_q;
  longint      xspan_q, yspan_q;
  logic [12:0] width_q, height_q;
  logic [31:0] palette_q [PAL_DEPTH];
  out_item_t   color_queue [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = color_queue.size();

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint mul_floor(longint a, longint b, int sh);
    return clamp_q((a * b) >>> sh);
  endfunction

  function automatic longint plane_coord(longint vmin, longint span, longint pix,
                                         logic [12:0] frame);
    longint div;
    div = (frame == 0) ? 1 : ((frame > MAX_DIM) ? MAX_DIM : longint'(frame));
    return clamp_q(vmin + (span * pix) / div);
  endfunction

  function automatic out_item_t shade_pixel(logic [11:0] pix_x, logic [11:0] pix_y);
    out_item_t res;
    longint lim, px, py, zx, zy, cx, cy, x2, y2, tx, ty;
    lim = (limit_q > MAX_ITER) ? MAX_ITER : longint'(limit_q);
    px = plane_coord(xmin_q, xspan_q, pix_x, width_q);
    py = plane_coord(ymin_q, yspan_q, pix_y, height_q);
    if (kind_q == KIND_JULIA) begin
      zx = px; zy = py; cx = SEED_RE; cy = SEED_IM;
    end else begin
      zx = 0; zy = 0; cx = px; cy = mul_floor(py, ASPECT_Q32, 32);
    end
    res.pixel_color = palette_q[PAL_DEPTH-1];
    res.escape_step = STEP_W'(lim);
    res.inside_set  = 1'b1;
    for (longint i = 0; i < lim; i++) begin
      x2 = mul_floor(zx, zx, 28);
      y2 = mul_floor(zy, zy, 28);
      if (x2 + y2 > R2_LIMIT) begin
        res.pixel_color = palette_q[((i * 256) / lim) & 255];
        res.escape_step = STEP_W'(i);
        res.inside_set  = 1'b0;
        return res;
      end
      tx = zx; ty = zy;
      if (kind_q == KIND_SHIP) begin
        if (tx < 0) tx = -tx;
        if (ty < 0) ty = -ty;
      end
      zx = clamp_q(x2 - y2 + cx);
      zy = clamp_q(mul_floor(tx, ty, 27) + cy);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    fails++;
  endtask

  initial begin
    kind_q = 2'd0; limit_q = 13'd100;
    xmin_q = -536870912; xspan_q = 1073741824;
    ymin_q = -536870912; yspan_q = 1073741824;
    width_q = 13'd640; height_q = 13'd480;
    fails = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_KIND:   kind_q   = cfg_data_i[1:0];
          CFG_LIMIT:  limit_q  = cfg_data_i[12:0];
          CFG_XMIN:   xmin_q   = longint'(signed'(cfg_data_i));
          CFG_XSPAN:  xspan_q  = longint'(cfg_data_i[30:0]);
          CFG_YMIN:   ymin_q   = longint'(signed'(cfg_data_i));
          CFG_YSPAN:  yspan_q  = longint'(cfg_data_i[30:0]);
          CFG_WIDTH:  width_q  = cfg_data_i[12:0];
          CFG_HEIGHT: height_q = cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.op == OP_PAL_WR) begin
          if (in_data_i.palette_index < PAL_DEPTH)
            palette_q[in_data_i.palette_index] = in_data_i.palette_color;
        end else begin
          color_queue.push_back(shade_pixel(in_data_i.pixel_x, in_data_i.pixel_y));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (color_queue.size() == 0) begin
          $display("[%0t] unexpected result 0x%0h", $time, out_data_i);
          fails++;
        end else begin
          out_item_t want;
          want = color_queue.pop_front();
          if (out_data_i.pixel_color !== want.pixel_color)
            report_mismatch("pixel_color", out_data_i.pixel_color, want.pixel_color);
          if (out_data_i.escape_step !== want.escape_step)
            report_mismatch("escape_step", out_data_i.escape_step, want.escape_step);
          if (out_data_i.inside_set !== want.inside_set)
            report_mismatch("inside_set", out_data_i.inside_set, want.inside_set);
        end
      end
    end
  end

endmodule

/* bench/escape_time_fractal_pixel_top_tb.sv */
`timescale 1ns / 1ps
module escape_time_fractal_pixel_top_tb;
  import etf_pkg::*;

  localparam int NUM_PHASES = 16;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  bit          quiet;
  int          renders;
  int          pal_writes;
  logic [12:0] width_sh, height_sh;

  escape_time_fractal_pixel_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  escape_time_fractal_pixel_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver back-pressure in bursts
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(in_item_t it);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    if (it.op == OP_RENDER) renders++;
    else pal_writes++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic render(int px, int py);
    in_item_t it;
    it = in_item_t'({2'b00, $urandom, $urandom});
    it.op = OP_RENDER;
    it.pixel_x = PIX_W'(px);
    it.pixel_y = PIX_W'(py);
    send_request(it);
  endtask

  task automatic load_palette(int idx, logic [31:0] color);
    in_item_t it;
    it = in_item_t'({2'b00, $urandom, $urandom});
    it.op = OP_PAL_WR;
    it.palette_index = PAL_AW'(idx);
    it.palette_color = color;
    send_request(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // a trailing palette write leaves no result behind
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH) width_sh = value[12:0];
    if (idx == CFG_HEIGHT) height_sh = value[12:0];
  endtask

  function automatic int pick_pixel(logic [12:0] frame);
    if (frame == 0 || frame > 4096 || $urandom_range(0, 4) == 0)
      return $urandom_range(0, 4095);
    return $urandom_range(0, frame - 1);
  endfunction

  task automatic setup_phase(int p);
    logic [31:0] lim;
    bit          wild;
    wild = (p == 10 || p == 11);
    case (p)
      3:       lim = 32'd0;
      5:       lim = 32'd1;
      7:       lim = 32'd4096;
      9:       lim = 32'd8191;
      default: lim = $urandom_range(2, 160);
    endcase
    if (wild) lim = $urandom_range(1, 127) | ($urandom & 32'hFFFF_E000);
    write_reg(CFG_KIND, wild ? $urandom : 32'(p % 4));
    write_reg(CFG_LIMIT, lim);
    case (p)
      2: begin
        write_reg(CFG_XMIN, 32'h8000_0000);
        write_reg(CFG_XSPAN, 32'h7FFF_FFFF);
        write_reg(CFG_YMIN, 32'h8000_0000);
        write_reg(CFG_YSPAN, 32'h7FFF_FFFF);
      end
      4: begin
        write_reg(CFG_XMIN, 32'h7FFF_FFFF);
        write_reg(CFG_XSPAN, 32'h0);
        write_reg(CFG_YMIN, 32'h7FFF_FFFF);
        write_reg(CFG_YSPAN, 32'h0);
      end
      10, 11: begin
        write_reg(CFG_XMIN, $urandom);
        write_reg(CFG_XSPAN, $urandom);
        write_reg(CFG_YMIN, $urandom);
        write_reg(CFG_YSPAN, $urandom);
      end
      default: begin
        // a window around the interesting region, about -2.5..1.5
        write_reg(CFG_XMIN, 32'(-671088640 + int'($urandom_range(0, 1 << 27))));
        write_reg(CFG_XSPAN, $urandom_range(1 << 28, 1 << 30));
        write_reg(CFG_YMIN, 32'(-536870912 + int'($urandom_range(0, 1 << 27))));
        write_reg(CFG_YSPAN, $urandom_range(1 << 28, 1 << 30));
      end
    endcase
    case (p)
      6: begin
        write_reg(CFG_WIDTH, 32'd0);
        write_reg(CFG_HEIGHT, 32'd8191);
      end
      8: begin
        write_reg(CFG_WIDTH, 32'd1);
        write_reg(CFG_HEIGHT, 32'd4096);
      end
      10, 11: begin
        write_reg(CFG_WIDTH, $urandom);
        write_reg(CFG_HEIGHT, $urandom);
      end
      default: begin
        write_reg(CFG_WIDTH, $urandom_range(16, 640));
        write_reg(CFG_HEIGHT, $urandom_range(16, 480));
      end
    endcase
  endtask

  initial begin
    int n_items;
    quiet = 1'b0;
    renders = 0;
    pal_writes = 0;
    width_sh = 13'd640;
    height_sh = 13'd480;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_KIND;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every palette entry is loaded before any render can read it
    for (int i = 0; i < PAL_DEPTH; i++) load_palette(i, $urandom);

    // directed, under the reset configuration
    load_palette(256, 32'hFFFF_FFFF);
    load_palette(0, 32'h0);
    load_palette(300, 32'h1234_5678);
    load_palette(511, 32'hDEAD_BEEF);
    render(0, 0);
    render(4095, 4095);
    render(320, 240);
    render(4095, 0);
    render(0, 4095);
    render(639, 479);
    render(160, 240);
    render(400, 200);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      setup_phase(p);
      if (p >= NUM_PHASES - 3) quiet = 1'b1;
      n_items = (p == 7 || p == 9) ? 4 : 48;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 6) == 0)
          load_palette(($urandom_range(0, 9) == 0) ? $urandom_range(257, 511)
                                                   : $urandom_range(0, 256), $urandom);
        else
          render(pick_pixel(width_sh), pick_pixel(height_sh));
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d pixel renders and %0d palette writes", renders, pal_writes);
    $display("over %0d register settings, all fractal kinds and limit extremes",
             NUM_PHASES + 1);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
